// ===== sv/assert_macros.svh =====
// Assertion macros used by the evaluator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, prop)
`endif

`endif

// ===== sv/pee_pkg.sv =====
// Types and constants of the postfix expression evaluator.
`default_nettype none
package pee_pkg;

  localparam logic [7:0] CH_EQ  = 8'h3D;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [7:0] CH_ADD = 8'h2B;
  localparam logic [7:0] CH_SUB = 8'h2D;
  localparam logic [7:0] CH_MUL = 8'h2A;
  localparam logic [7:0] CH_DIV = 8'h2F;

  localparam logic [2:0] STAT_ACCEPT   = 3'd0;
  localparam logic [2:0] STAT_RESULT   = 3'd1;
  localparam logic [2:0] STAT_LEFTOVER = 3'd2;
  localparam logic [2:0] STAT_FEW      = 3'd3;
  localparam logic [2:0] STAT_DIVZERO  = 3'd4;
  localparam logic [2:0] STAT_INVALID  = 3'd5;
  localparam logic [2:0] STAT_OVERFLOW = 3'd6;

  localparam int DW        = 32;
  localparam int DIV_STEPS = DW;
  localparam int DCW       = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EQ,
    S_RHS,
    S_LHS,
    S_DIV,
    S_WB,
    S_FIN
  } state_e;

endpackage
`default_nettype wire

// ===== sv/postfix_expression_evaluator_unit.sv =====
// Digits, invalid chars and stack errors give a word from idle, or wait in S_FIN if held.
// '=' with one value: S_EQ, S_FIN; '+' '-' '*': S_RHS, S_LHS, S_WB, S_FIN; '/' adds S_DIV
// (restoring, one quotient bit per cycle), divide by zero skips S_WB; one char at a time.
// The block takes a new character in idle while one finished word may wait at the output.
// Reset clears the stack count, sequencer and output valid; stack memory is not cleared
// (only written entries are read), so no clearing pass follows reset.
`default_nettype none
`include "assert_macros.svh"
module postfix_expression_evaluator_unit #(
  parameter int STACK_DEPTH = 128
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [7:0]           char_code_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [2:0]                status_o,
  output logic signed [pee_pkg::DW-1:0] value_o
);
  import pee_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int IW = $clog2(STACK_DEPTH);

  logic [DW-1:0] mem_q [STACK_DEPTH];
  logic [DW-1:0] rdata_q;
  logic [IW-1:0] raddr, waddr;
  logic [DW-1:0] wdata;
  logic          mem_we;

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;
  op_e           op_q, op_d;
  logic [DW-1:0] rhs_q, rhs_d, res_q, res_d, rem_q, rem_d, divr_q, divr_d;
  logic          neg_q, neg_d;
  logic [DCW-1:0] dcnt_q, dcnt_d;
  logic [2:0]    stat_q, stat_d, out_status_q, out_status_d;
  logic [DW-1:0] out_value_q, out_value_d;

  logic [CW-1:0] cnt_m1, cnt_m2;
  logic          is_digit, is_op, out_free, accept;
  logic [DW-1:0] prod;
  logic [DW:0]   rem_sh, diff;

  assign cnt_m1   = cnt_q - CW'(1);
  assign cnt_m2   = cnt_q - CW'(2);
  assign is_digit = (char_code_i >= CH_0) && (char_code_i <= CH_9);
  assign is_op    = (char_code_i == CH_ADD) || (char_code_i == CH_SUB) ||
                    (char_code_i == CH_MUL) || (char_code_i == CH_DIV);
  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign accept   = in_valid_i && in_ready_o;
  assign prod     = rdata_q * rhs_q;
  assign rem_sh   = {rem_q, res_q[DW-1]};
  assign diff     = rem_sh - {1'b0, divr_q};
  assign raddr    = (state_q == S_IDLE) ? cnt_m1[IW-1:0] : cnt_m2[IW-1:0];

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign value_o     = out_value_q;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q;
    op_d         = op_q;
    rhs_d        = rhs_q;
    res_d        = res_q;
    rem_d        = rem_q;
    divr_d       = divr_q;
    neg_d        = neg_q;
    dcnt_d       = dcnt_q;
    stat_d       = stat_q;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    mem_we       = 1'b0;
    waddr        = cnt_q[IW-1:0];
    wdata        = {{(DW-4){1'b0}}, char_code_i[3:0]};

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (char_code_i == CH_EQ) begin
            cnt_d = '0;
            if (cnt_q == CW'(1)) begin
              state_d = S_EQ;
            end else begin
              stat_d  = (cnt_q == '0) ? STAT_FEW : STAT_LEFTOVER;
              state_d = S_FIN;
            end
          end else if (is_digit) begin
            state_d = S_FIN;
            if (cnt_q >= CW'(STACK_DEPTH)) begin
              stat_d = STAT_OVERFLOW;
              cnt_d  = '0;
            end else begin
              mem_we = 1'b1;
              cnt_d  = cnt_q + CW'(1);
              stat_d = STAT_ACCEPT;
            end
          end else if (is_op) begin
            if (cnt_q < CW'(2)) begin
              stat_d  = STAT_FEW;
              cnt_d   = '0;
              state_d = S_FIN;
            end else begin
              unique case (char_code_i)
                CH_ADD:  op_d = OP_ADD;
                CH_SUB:  op_d = OP_SUB;
                CH_MUL:  op_d = OP_MUL;
                default: op_d = OP_DIV;
              endcase
              state_d = S_RHS;
            end
          end else begin
            stat_d  = STAT_INVALID;
            state_d = S_FIN;
          end
          // immediate word goes straight out unless the output is held
          if ((state_d == S_FIN) && out_free) begin
            out_valid_d  = 1'b1;
            out_status_d = stat_d;
            out_value_d  = '0;
            state_d      = S_IDLE;
          end
        end
      end
      S_EQ: begin
        res_d   = rdata_q;
        stat_d  = STAT_RESULT;
        state_d = S_FIN;
      end
      S_RHS: begin
        rhs_d   = rdata_q;
        state_d = S_LHS;
      end
      S_LHS: begin
        neg_d   = 1'b0;
        state_d = S_WB;
        unique case (op_q)
          OP_ADD: res_d = rdata_q + rhs_q;
          OP_SUB: res_d = rdata_q - rhs_q;
          OP_MUL: res_d = prod;
          OP_DIV: begin
            if (rhs_q == '0) begin
              stat_d  = STAT_DIVZERO;
              cnt_d   = '0;
              state_d = S_FIN;
            end else begin
              neg_d   = rdata_q[DW-1] ^ rhs_q[DW-1];
              res_d   = rdata_q[DW-1] ? ('0 - rdata_q) : rdata_q;
              divr_d  = rhs_q[DW-1] ? ('0 - rhs_q) : rhs_q;
              rem_d   = '0;
              dcnt_d  = '0;
              state_d = S_DIV;
            end
          end
          default: res_d = res_q;
        endcase
      end
      S_DIV: begin
        if (!diff[DW]) begin
          rem_d = diff[DW-1:0];
          res_d = {res_q[DW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[DW-1:0];
          res_d = {res_q[DW-2:0], 1'b0};
        end
        dcnt_d = dcnt_q + DCW'(1);
        if (dcnt_q == DCW'(DIV_STEPS - 1)) state_d = S_WB;
      end
      S_WB: begin
        mem_we  = 1'b1;
        waddr   = cnt_m2[IW-1:0];
        wdata   = neg_q ? ('0 - res_q) : res_q;
        cnt_d   = cnt_m1;
        stat_d  = STAT_ACCEPT;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = stat_q;
          out_value_d  = (stat_q == STAT_RESULT) ? res_q : '0;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    rhs_q        <= rhs_d;
    res_q        <= res_d;
    rem_q        <= rem_d;
    divr_q       <= divr_d;
    neg_q        <= neg_d;
    dcnt_q       <= dcnt_d;
    stat_q       <= stat_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[waddr] <= wdata;
    rdata_q <= mem_q[raddr];
  end

  `ASSERT_CLK(a_cnt_bound, clk_i, rst_ni, cnt_q <= CW'(STACK_DEPTH))
  `ASSERT_NEVER(a_value_zero, clk_i, rst_ni, out_valid_o && (status_o != STAT_RESULT) && (value_o != '0))
  `ASSERT_CLK(a_op_start, clk_i, rst_ni, (accept && is_op && (cnt_q >= CW'(2))) |=> (state_q == S_RHS))

endmodule
`default_nettype wire

// ===== tb/sv/postfix_expression_evaluator_unit_test.sv =====
// Self-checking testbench for the postfix expression evaluator unit.
`timescale 1ns / 100ps
module postfix_expression_evaluator_unit_test;
  import pee_pkg::*;

  localparam int          STACK_DEPTH = 128;
  localparam int unsigned ITEM_TARGET = 2000;
  localparam int unsigned STUCK_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS = 200;
  localparam int unsigned DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] value;
  } word_t;

  typedef enum {EXPR_CLEAN, EXPR_NO_END, EXPR_EXTRA_OPERAND, EXPR_EARLY_OP} expr_form_e;
  typedef enum {RX_OPEN, RX_COIN, RX_COMB, RX_CHOKE} rx_mode_e;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        char_code = 8'h00;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [2:0]        status;
  logic signed [31:0] value;

  logic [7:0]  char_q[$];
  word_t       result_q[$];
  int unsigned n_items = 0;
  int unsigned n_total = 0;
  int unsigned n_accepted = 0;
  int unsigned err_cnt = 0;
  int unsigned stuck_cycles = 0;

  // evaluator mirror
  logic [31:0] operand_mem[STACK_DEPTH];
  int unsigned operand_cnt = 0;

  postfix_expression_evaluator_unit #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .char_code_i(char_code),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .status_o   (status),
    .value_o    (value)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic bit is_digit(logic [7:0] ch);
    return ch >= CH_0 && ch <= CH_9;
  endfunction

  function automatic bit is_op(logic [7:0] ch);
    return ch == CH_ADD || ch == CH_SUB || ch == CH_MUL || ch == CH_DIV;
  endfunction

  function automatic bit is_ignored(logic [7:0] ch);
    return !is_digit(ch) && !is_op(ch) && ch != CH_EQ;
  endfunction

  function automatic logic [31:0] div_toward_zero(logic [31:0] lhs, logic [31:0] rhs);
    logic [31:0] mag_l;
    logic [31:0] mag_r;
    logic [31:0] quo;
    mag_l = lhs[31] ? 32'd0 - lhs : lhs;
    mag_r = rhs[31] ? 32'd0 - rhs : rhs;
    quo = mag_l / mag_r;
    return (lhs[31] ^ rhs[31]) ? 32'd0 - quo : quo;
  endfunction

  // Applies one character to the mirrored stack and returns the word it yields.
  function automatic word_t eval_char(logic [7:0] ch);
    word_t       w;
    logic [31:0] lhs;
    logic [31:0] rhs;
    logic [31:0] res;
    w.status = STAT_ACCEPT;
    w.value  = 32'd0;
    if (ch == CH_EQ) begin
      if (operand_cnt == 0) begin
        w.status = STAT_FEW;
      end else if (operand_cnt == 1) begin
        w.status = STAT_RESULT;
        w.value  = operand_mem[0];
      end else begin
        w.status = STAT_LEFTOVER;
      end
      operand_cnt = 0;
    end else if (is_digit(ch)) begin
      if (operand_cnt >= STACK_DEPTH) begin
        w.status = STAT_OVERFLOW;
        operand_cnt = 0;
      end else begin
        operand_mem[operand_cnt] = {24'd0, ch - CH_0};
        operand_cnt++;
      end
    end else if (is_op(ch)) begin
      if (operand_cnt < 2) begin
        w.status = STAT_FEW;
        operand_cnt = 0;
      end else begin
        rhs = operand_mem[operand_cnt - 1];
        lhs = operand_mem[operand_cnt - 2];
        res = 32'd0;
        if (ch == CH_ADD) begin
          res = lhs + rhs;
        end else if (ch == CH_SUB) begin
          res = lhs - rhs;
        end else if (ch == CH_MUL) begin
          res = lhs * rhs;
        end else if (rhs == 32'd0) begin
          w.status = STAT_DIVZERO;
        end else begin
          res = div_toward_zero(lhs, rhs);
        end
        if (w.status == STAT_DIVZERO) begin
          operand_cnt = 0;
        end else begin
          operand_mem[operand_cnt - 2] = res;
          operand_cnt--;
        end
      end
    end else begin
      w.status = STAT_INVALID;
    end
    return w;
  endfunction

  function automatic logic [7:0] digit_char(int unsigned d);
    return CH_0 + d[7:0];
  endfunction

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 3))
      0: return CH_ADD;
      1: return CH_SUB;
      2: return CH_MUL;
      default: return CH_DIV;
    endcase
  endfunction

  function automatic logic [7:0] pick_junk();
    logic [7:0] ch;
    ch = 8'($urandom_range(0, 255));
    while (!is_ignored(ch)) ch = 8'($urandom_range(0, 255));
    return ch;
  endfunction

  task automatic push_char(logic [7:0] ch);
    char_q.push_back(ch);
    if (!is_ignored(ch)) n_items++;
  endtask

  task automatic gen_expr(int unsigned leaves, expr_form_e form);
    int unsigned depth;
    int unsigned left;
    depth = 0;
    left  = leaves;
    if (form == EXPR_EARLY_OP) push_char(pick_op());
    while (left != 0 || depth > 1) begin
      if ($urandom_range(0, 19) == 0) push_char(pick_junk());
      if (left != 0 && (depth < 2 || $urandom_range(0, 1) == 1)) begin
        push_char(digit_char($urandom_range(0, 9)));
        depth++;
        left--;
      end else begin
        push_char(pick_op());
        depth--;
      end
    end
    if (form == EXPR_EXTRA_OPERAND) push_char(digit_char($urandom_range(0, 9)));
    if (form != EXPR_NO_END) push_char(CH_EQ);
  endtask

  // 2 * 64^5 wraps to the most negative value, then a random tail.
  task automatic gen_extreme();
    push_char(CH_EQ);
    push_char(digit_char(2));
    repeat (5) begin
      push_char(digit_char(8));
      push_char(digit_char(8));
      push_char(CH_MUL);
    end
    repeat (5) push_char(CH_MUL);
    case ($urandom_range(0, 2))
      0: begin
        push_char(digit_char(0));
        push_char(digit_char(1));
        push_char(CH_SUB);
        push_char(CH_DIV);
      end
      1: begin
        push_char(digit_char(1));
        push_char(CH_SUB);
      end
      default: ;
    endcase
    push_char(CH_EQ);
  endtask

  task automatic gen_deep();
    push_char(CH_EQ);
    repeat (STACK_DEPTH) push_char(digit_char($urandom_range(0, 9)));
    if ($urandom_range(0, 1) == 0) begin
      push_char(digit_char($urandom_range(0, 9)));
    end else begin
      repeat (STACK_DEPTH - 1) begin
        if ($urandom_range(0, 9) == 0) push_char(CH_DIV);
        else push_char(pick_op());
      end
      push_char(CH_EQ);
    end
  endtask

  task automatic push_str(string s);
    foreach (s[k]) push_char(s[k]);
  endtask

  initial begin
    // invalid extremes, empty-stack cases, every operator, a negative quotient
    push_char(8'h00);
    push_char(CH_EQ);
    push_char(CH_ADD);
    push_str("90/");
    push_str("34=");
    push_str("72-3*6+=");
    push_str("07-");
    push_char(8'hFF);
    push_str("2/=");

    while (n_items < ITEM_TARGET) begin
      case ($urandom_range(0, 99)) inside
        [0:69]: begin
          if ($urandom_range(0, 7) == 0) gen_expr($urandom_range(10, 30), EXPR_CLEAN);
          else gen_expr($urandom_range(1, 9), EXPR_CLEAN);
        end
        [70:79]: gen_expr($urandom_range(1, 6), expr_form_e'($urandom_range(1, 3)));
        [80:87]: repeat ($urandom_range(1, 4)) push_char(8'($urandom_range(0, 255)));
        [88:94]: gen_extreme();
        [95:96]: gen_deep();
        default: push_char($urandom_range(0, 1) ? CH_EQ : pick_op());
      endcase
    end
    n_total = char_q.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (n_accepted != n_total) @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0 && result_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // sender: bursts of random length separated by random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk) begin : feed
    word_t want;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        want = eval_char(char_code);
        result_q.push_back(want);
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (char_q.size() != 0) begin
          char_code <= char_q.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 9)) inside
              [0:3]: gap_left = 0;
              [4:8]: gap_left = $urandom_range(1, 8);
              default: gap_left = $urandom_range(20, 60);
            endcase
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern switches between modes over random windows
  rx_mode_e    rx_mode = RX_OPEN;
  int unsigned rx_left = 0;
  int unsigned rx_tick = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(8, 120);
        rx_tick = 0;
      end else begin
        rx_left--;
      end
      rx_tick++;
      case (rx_mode)
        RX_OPEN: out_ready <= 1'b1;
        RX_COIN: out_ready <= 1'($urandom_range(0, 1));
        RX_COMB: out_ready <= (rx_tick % 4 == 0);
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin : watch
    word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("%0t: unexpected word: expected none actual status %0d value %0d",
                   $time, status, value);
      end else begin
        want = result_q.pop_front();
        if (status !== want.status) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.status, status);
        end
        if (value !== want.value) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("%0t: value mismatch: expected %0d actual %0d",
                     $time, $signed(want.value), value);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/pee_pkg.sv
sv/postfix_expression_evaluator_unit.sv
tb/sv/postfix_expression_evaluator_unit_test.sv
